### hdl/hbps_pkg.sv
// Package for the Heston barrier path stepper: register map, register file
// type, stored path state, pipeline item type and fixed-point helpers.
// No dependencies.
package hbps_pkg;

  localparam int Z_FRAC = 12;
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_DRIFT      = 3'd0,
    REG_SQRT_STEP  = 3'd1,
    REG_REVERSION  = 3'd2,
    REG_LTV        = 3'd3,
    REG_VOLVOL     = 3'd4,
    REG_LOWER      = 3'd5,
    REG_UPPER      = 3'd6,
    REG_INIT_VAR   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] drift;
    logic [30:0]        sqrt_step;
    logic [30:0]        reversion;
    logic [30:0]        ltv;
    logic [30:0]        volvol;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    logic [30:0]        init_var;
  } cfg_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] variance;
    logic signed [31:0] log_ret;
  } path_state_t;

  localparam int STATE_W = $bits(path_state_t);

  typedef struct packed {
    logic [5:0]         id;
    logic               last;
    logic signed [15:0] zp;
    logic signed [15:0] zv;
    path_state_t        st;
  } item_tag_t;

  localparam int TAG_W = $bits(item_tag_t);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return x[31:0];
    end
  endfunction

  // floored product, scaled down by 2^sh and clamped to 32 bits
  function automatic logic signed [31:0] mul_floor(input logic signed [31:0] a,
                                                    input logic signed [31:0] b,
                                                    input int unsigned sh);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat32(p >>> sh);
  endfunction

endpackage

### hdl/hbps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hbps_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/hbps_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a tag that
// travels alongside. Depends on nothing but its parameters.
module hbps_sqrt #(
  parameter int RW = 55,
  parameter int TW = 8,
  localparam int SB = (RW + 1) / 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [RW-1:0] radicand,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [SB-1:0] root,
  output logic [TW-1:0] out_tag
);

  localparam int PW = 2 * SB;
  localparam int MW = SB + 3;

  logic [PW-1:0] rad_q  [SB];
  logic [MW-1:0] rem_q  [SB];
  logic [SB-1:0] root_q [SB];
  logic [TW-1:0] tag_q  [SB];
  logic [SB-1:0] vld_q;

  for (genvar i = 0; i < SB; i++) begin : g_step
    logic [PW-1:0] rad_in;
    logic [MW-1:0] rem_prev;
    logic [SB-1:0] root_in;
    logic [TW-1:0] tag_in;
    logic          vld_in;
    logic [MW-1:0] rem_in;
    logic [MW-1:0] trial;

    if (i == 0) begin : g_first
      assign rad_in   = PW'(radicand);
      assign rem_prev = '0;
      assign root_in  = '0;
      assign tag_in   = in_tag;
      assign vld_in   = in_valid;
    end else begin : g_next
      assign rad_in   = rad_q[i-1];
      assign rem_prev = rem_q[i-1];
      assign root_in  = root_q[i-1];
      assign tag_in   = tag_q[i-1];
      assign vld_in   = vld_q[i-1];
    end

    always_comb begin
      rem_in = {rem_prev[MW-3:0], rad_in[PW-1 -: 2]};
      trial  = MW'({root_in, 2'b01});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[i] <= rad_in << 2;
        tag_q[i] <= tag_in;
        if (rem_in >= trial) begin
          rem_q[i]  <= rem_in - trial;
          root_q[i] <= {root_in[SB-2:0], 1'b1};
        end else begin
          rem_q[i]  <= rem_in;
          root_q[i] <= {root_in[SB-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld_q[SB-1];
  assign root      = root_q[SB-1];
  assign out_tag   = tag_q[SB-1];

endmodule

### hdl/hbps_update.sv
// Euler update of one path step after the square root: three stages of
// products, sums and barrier bounds. Depends on hbps_pkg.
module hbps_update #(
  parameter int FRAC_BITS = 24,
  parameter int SB = 28
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [SB-1:0]       root,
  input  hbps_pkg::item_tag_t in_tag,
  input  hbps_pkg::cfg_t      cfg,
  input  logic signed [31:0]  half_step,
  input  logic signed [31:0]  corr_step,
  output logic                out_valid,
  output hbps_pkg::item_tag_t out_tag
);
  import hbps_pkg::*;

  logic [30:0]        m;
  logic signed [31:0] s32;
  logic signed [31:0] ltv_m;

  logic               a_valid;
  item_tag_t          a_tag;
  logic signed [31:0] a_mhs, a_sqs, a_rev, a_vvs, a_c;

  logic               b_valid;
  item_tag_t          b_tag;
  logic signed [31:0] b_dt, b_q, b_r, b_rev, b_c;

  logic               c_valid;
  item_tag_t          c_tag;
  item_tag_t          c_tag_next;
  logic signed [31:0] c_lower, c_upper;

  // variance is truncated at zero before it feeds the products; the variance sum uses it as stored
  always_comb begin
    m     = in_tag.st.variance[31] ? '0 : in_tag.st.variance[30:0];
    s32   = 32'(root);
    ltv_m = $signed({1'b0, cfg.ltv}) - $signed({1'b0, m});
  end

  // new log return and variance of the step
  always_comb begin
    c_tag_next             = b_tag;
    c_tag_next.st.log_ret  = sat32(64'(b_tag.st.log_ret) + 64'(b_dt) + 64'(b_q));
    c_tag_next.st.variance = sat32(64'(b_tag.st.variance) + 64'(b_rev) + 64'(b_r));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_tag <= in_tag;
      a_mhs <= mul_floor($signed({1'b0, m}), half_step, FRAC_BITS);
      a_sqs <= mul_floor($signed({1'b0, cfg.sqrt_step}), s32, FRAC_BITS);
      a_rev <= mul_floor($signed({1'b0, cfg.reversion}), ltv_m, FRAC_BITS);
      a_vvs <= mul_floor($signed({1'b0, cfg.volvol}), s32, FRAC_BITS);
      a_c   <= mul_floor(corr_step, s32, FRAC_BITS);

      b_tag <= a_tag;
      b_dt  <= sat32(64'(cfg.drift) - 64'(a_mhs));
      b_q   <= mul_floor(a_sqs, 32'(a_tag.zp), Z_FRAC);
      b_r   <= mul_floor(a_vvs, 32'(a_tag.zv), Z_FRAC);
      b_rev <= a_rev;
      b_c   <= a_c;

      c_tag   <= c_tag_next;
      c_lower <= sat32(64'(cfg.lower) + 64'(b_c));
      c_upper <= sat32(64'(cfg.upper) - 64'(b_c));
    end
  end

  // merge this step's barrier test into the sticky flag
  always_comb begin
    out_tag        = c_tag;
    out_tag.st.hit = c_tag.st.hit | (c_tag.st.log_ret < c_lower)
                   | (c_tag.st.log_ret > c_upper);
  end

  assign out_valid = c_valid;

endmodule

### hdl/heston_barrier_path_step.sv
// Top level of the Heston barrier path stepper: register file, path state
// memory with read-modify-write pipeline, slot interlock and output register.
// Depends on hbps_pkg, hbps_ram, hbps_sqrt and hbps_update.
//
// Usage: each request on the input channel (in_valid/in_stall) names a path
// slot and carries two Gaussian samples; it advances that path by one Euler
// step. A request with last_step set yields one result on the output channel
// (out_valid/out_stall); other requests yield none. Results leave in request
// order. Each request passes the state read stage, the bit-serial square root
// pipeline and the update stages; results then enter the output register.
// Throughput is one request per cycle as long as the slot named is not still
// in flight: the path state memory is read at acceptance and written back at
// the end of the pipeline, so a slot may re-enter only once its previous step
// has been written back. Interleaving enough slots that none re-enters while in
// flight keeps the rate at one per cycle unless the output register holds it.
// Reset clears the pipeline and loads the registers with their reset values;
// the path memory is not cleared, each path starts with a first_step request.
// While a finished result waits under out_stall, requests that produce no
// result keep flowing; the pipeline holds only when the next result would
// overrun the output register.
module heston_barrier_path_step #(
  parameter int PATH_SLOTS = 64,
  parameter int FRAC_BITS  = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hbps_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [5:0]                  path_slot,
  input  logic                        first_step,
  input  logic                        last_step,
  input  logic signed [15:0]          z_price,
  input  logic signed [15:0]          z_variance,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [5:0]                  done_slot,
  output logic signed [31:0]          final_log_return,
  output logic                        knocked_out
);
  import hbps_pkg::*;

  localparam int SW    = (PATH_SLOTS > 1) ? $clog2(PATH_SLOTS) : 1;
  localparam int RW    = 31 + FRAC_BITS;
  localparam int SB    = (RW + 1) / 2;
  localparam int DEPTH = SB + 4;
  localparam longint K_CORR = (64'd5826 * (64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;

  cfg_t               cfg;
  reg_idx_t           reg_idx;
  logic               cfg_wr;
  logic signed [31:0] half_step;
  logic signed [31:0] corr_step;

  logic [SW-1:0]      mod_tab [64];
  logic [SW-1:0]      slot_in;
  logic               hazard;
  logic               en;
  logic               accept;

  logic               hz_valid [DEPTH];
  logic [SW-1:0]      hz_slot  [DEPTH];

  logic               p1_valid;
  logic [5:0]         p1_id;
  logic               p1_first;
  logic               p1_last;
  logic signed [15:0] p1_zp;
  logic signed [15:0] p1_zv;
  path_state_t        rd_state;
  path_state_t        p1_state;
  logic [30:0]        p1_m;
  logic [RW-1:0]      p1_rad;
  item_tag_t          p1_tag;

  logic               sq_valid;
  logic [SB-1:0]      sq_root;
  logic [TAG_W-1:0]   sq_tag;

  logic               upd_valid;
  item_tag_t          upd_tag;
  logic               ram_we;
  logic [SW-1:0]      wr_slot;

  // ---------------- register file ----------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{drift: '0, sqrt_step: '0, reversion: '0, ltv: '0, volvol: '0,
               lower: 32'sh8000_0000, upper: 32'sh7fff_ffff, init_var: '0};
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DRIFT:     cfg.drift     <= pwdata;
        REG_SQRT_STEP: cfg.sqrt_step <= pwdata[30:0];
        REG_REVERSION: cfg.reversion <= pwdata[30:0];
        REG_LTV:       cfg.ltv       <= pwdata[30:0];
        REG_VOLVOL:    cfg.volvol    <= pwdata[30:0];
        REG_LOWER:     cfg.lower     <= pwdata;
        REG_UPPER:     cfg.upper     <= pwdata;
        REG_INIT_VAR:  cfg.init_var  <= pwdata[30:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DRIFT:     prdata = cfg.drift;
      REG_SQRT_STEP: prdata = {1'b0, cfg.sqrt_step};
      REG_REVERSION: prdata = {1'b0, cfg.reversion};
      REG_LTV:       prdata = {1'b0, cfg.ltv};
      REG_VOLVOL:    prdata = {1'b0, cfg.volvol};
      REG_LOWER:     prdata = cfg.lower;
      REG_UPPER:     prdata = cfg.upper;
      REG_INIT_VAR:  prdata = {1'b0, cfg.init_var};
    endcase
  end

  // step constants that depend on the registers alone
  always_ff @(posedge clk) begin
    half_step <= mul_floor($signed({1'b0, cfg.sqrt_step}), $signed({1'b0, cfg.sqrt_step}),
                           FRAC_BITS + 1);
    corr_step <= mul_floor(32'(K_CORR), $signed({1'b0, cfg.sqrt_step}), FRAC_BITS);
  end

  // ---------------- acceptance and slot interlock ----------------
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      mod_tab[i] = SW'(i % PATH_SLOTS);
    end
  end

  assign slot_in = mod_tab[path_slot];

  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hz_valid[i] && hz_slot[i] == slot_in) begin
        hazard = 1'b1;
      end
    end
  end

  // hold the pipeline only when a result would overrun the output register
  assign en       = !(upd_valid && upd_tag.last && out_valid && out_stall);
  assign in_stall = !en || hazard;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        hz_valid[i] <= 1'b0;
      end
    end else if (en) begin
      hz_valid[0] <= accept;
      for (int i = 1; i < DEPTH; i++) begin
        hz_valid[i] <= hz_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hz_slot[0] <= slot_in;
      for (int i = 1; i < DEPTH; i++) begin
        hz_slot[i] <= hz_slot[i-1];
      end
    end
  end

  // ---------------- path state memory ----------------
  assign wr_slot = mod_tab[upd_tag.id];
  assign ram_we  = upd_valid && en;

  hbps_ram #(
    .WIDTH (STATE_W),
    .DEPTH (PATH_SLOTS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_slot),
    .wdata (upd_tag.st),
    .re    (en),
    .raddr (slot_in),
    .rdata (rd_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_id    <= path_slot;
      p1_first <= first_step;
      p1_last  <= last_step;
      p1_zp    <= z_price;
      p1_zv    <= z_variance;
    end
  end

  // a first step starts from the spot price and the initial variance
  always_comb begin
    if (p1_first) begin
      p1_state = '{hit: 1'b0, variance: $signed({1'b0, cfg.init_var}), log_ret: '0};
    end else begin
      p1_state = rd_state;
    end
    p1_m   = p1_state.variance[31] ? '0 : p1_state.variance[30:0];
    p1_rad = {p1_m, {FRAC_BITS{1'b0}}};
    p1_tag = '{id: p1_id, last: p1_last, zp: p1_zp, zv: p1_zv, st: p1_state};
  end

  hbps_sqrt #(
    .RW (RW),
    .TW (TAG_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p1_valid),
    .radicand  (p1_rad),
    .in_tag    (p1_tag),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_tag   (sq_tag)
  );

  hbps_update #(
    .FRAC_BITS (FRAC_BITS),
    .SB        (SB)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .root      (sq_root),
    .in_tag    (item_tag_t'(sq_tag)),
    .cfg       (cfg),
    .half_step (half_step),
    .corr_step (corr_step),
    .out_valid (upd_valid),
    .out_tag   (upd_tag)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= upd_valid && upd_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if ((!out_valid || !out_stall) && upd_valid && upd_tag.last) begin
      done_slot        <= upd_tag.id;
      final_log_return <= upd_tag.st.log_ret;
      knocked_out      <= upd_tag.st.hit;
    end
  end

  // ---------------- checks ----------------
  a_track_aligned: assert property (@(posedge clk) disable iff (rst)
    hz_valid[DEPTH-1] == upd_valid)
    else $error("interlock line out of step with the update pipeline");

  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (rst)
    (accept && ram_we) |-> (wr_slot != slot_in))
    else $error("slot read while its write-back is pending");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (upd_valid && upd_tag.last && en) |=> out_valid)
    else $error("finished path result dropped");

endmodule

### dv/heston_barrier_path_step_tb.sv
// Testbench for heston_barrier_path_step: drives path-step requests and APB register writes,
// predicts each final log return and knock-out flag, and checks every result in order.
// Depends on hbps_pkg and the RTL of the block.
class path_scoreboard;
  typedef struct {
    logic [5:0]         slot;
    logic signed [31:0] log_ret;
    logic               hit;
  } done_t;

  logic signed [31:0] drift, lower, upper;
  logic [30:0]        sqrt_step, reversion, ltv, volvol, init_var;
  logic signed [31:0] lr_mem [64];
  logic signed [31:0] var_mem [64];
  logic               hit_mem [64];
  done_t              pending_done[$];
  int                 errors;
  int                 checked;

  function new();
    drift = 0; sqrt_step = 0; reversion = 0; ltv = 0; volvol = 0;
    lower = 32'sh8000_0000; upper = 32'sh7fff_ffff; init_var = 0;
    errors = 0; checked = 0;
    for (int i = 0; i < 64; i++) begin
      lr_mem[i] = 0; var_mem[i] = 0; hit_mem[i] = 0;
    end
  endfunction

  function logic signed [31:0] clamp(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fff_ffff;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function logic signed [31:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b, int sh);
    logic signed [63:0] p;
    p = a * b;
    return clamp(p >>> sh);
  endfunction

  function logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function void set_reg(hbps_pkg::reg_idx_t idx, logic [31:0] val);
    case (idx)
      hbps_pkg::REG_DRIFT:     drift = val;
      hbps_pkg::REG_SQRT_STEP: sqrt_step = val[30:0];
      hbps_pkg::REG_REVERSION: reversion = val[30:0];
      hbps_pkg::REG_LTV:       ltv = val[30:0];
      hbps_pkg::REG_VOLVOL:    volvol = val[30:0];
      hbps_pkg::REG_LOWER:     lower = val;
      hbps_pkg::REG_UPPER:     upper = val;
      hbps_pkg::REG_INIT_VAR:  init_var = val[30:0];
      default: ;
    endcase
  endfunction

  function void note_request(logic [5:0] slot, logic first, logic last,
                             logic signed [15:0] zp, logic signed [15:0] zv);
    logic signed [63:0] lr, v, m, s, hs, sq, t, k, c, lo_b, up_b;
    logic               hit;
    done_t              d;
    if (first) begin
      lr_mem[slot] = 0; var_mem[slot] = init_var; hit_mem[slot] = 0;
    end
    lr = lr_mem[slot];
    v = var_mem[slot];
    hit = hit_mem[slot];
    sq = {33'd0, sqrt_step};
    m = v > 0 ? v : 0;
    s = int_sqrt(m << 24);
    hs = clamp((sq * sq) >>> 25);
    t = clamp(drift - fx_mul(m, hs, 24));
    lr = clamp(lr + t + fx_mul(fx_mul(sq, s, 24), zp, hbps_pkg::Z_FRAC));
    t = fx_mul({33'd0, reversion}, clamp({33'd0, ltv} - m), 24);
    v = clamp(v + t + fx_mul(fx_mul({33'd0, volvol}, s, 24), zv, hbps_pkg::Z_FRAC));
    k = (64'd5826 * (64'd1 << 24) + 64'd5000) / 64'd10000;
    c = fx_mul(fx_mul(k, sq, 24), s, 24);
    lo_b = clamp(lower + c);
    up_b = clamp(upper - c);
    if (lr < lo_b || lr > up_b) hit = 1;
    lr_mem[slot] = lr;
    var_mem[slot] = v;
    hit_mem[slot] = hit;
    if (last) begin
      d.slot = slot; d.log_ret = lr; d.hit = hit;
      pending_done.push_back(d);
    end
  endfunction

  function void check_result(logic [5:0] slot, logic signed [31:0] lr, logic hit);
    done_t d;
    checked++;
    if (pending_done.size() == 0) begin
      $error("result for slot %0d with nothing pending", slot);
      errors++;
      return;
    end
    d = pending_done.pop_front();
    if (slot !== d.slot) begin
      $error("done_slot expected %0d actual %0d", d.slot, slot);
      errors++;
    end
    if (lr !== d.log_ret) begin
      $error("final_log_return expected %0d actual %0d", d.log_ret, lr);
      errors++;
    end
    if (hit !== d.hit) begin
      $error("knocked_out expected %0d actual %0d", d.hit, hit);
      errors++;
    end
  endfunction
endclass

module heston_barrier_path_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hbps_pkg::*;

  localparam int LATENCY = 32;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic [5:0] path_slot = '0;
  logic first_step = 0, last_step = 0;
  logic signed [15:0] z_price = '0, z_variance = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [5:0] done_slot;
  logic signed [31:0] final_log_return;
  logic knocked_out;

  path_scoreboard sb = new();
  longint cycles = 0;
  bit calm = 0;      // long stretch without idling on either side
  bit started [64];
  int directed_cnt = 0, random_cnt = 0;

  always #5 clk = ~clk;

  heston_barrier_path_step DUT (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(done_slot, final_log_return, knocked_out);
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 8);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_step(logic [5:0] slot, logic first, logic last,
                           logic signed [15:0] zp, logic signed [15:0] zv);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; path_slot <= slot; first_step <= first; last_step <= last;
    z_price <= zp; z_variance <= zv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(slot, first, last, zp, zv);
    started[slot] = 1;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_done.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // gaussian-ish sample with occasional full-range extremes
  function automatic logic signed [15:0] rand_z();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(16000)) - 8000);
  endfunction

  task automatic program_regs(int mode);
    case (mode)
      0: begin
        write_reg(REG_DRIFT, 32'sd1000); write_reg(REG_SQRT_STEP, 32'd1677722);
        write_reg(REG_REVERSION, 32'd335544); write_reg(REG_LTV, 32'd671089);
        write_reg(REG_VOLVOL, 32'd838861); write_reg(REG_LOWER, -32'sd5000000);
        write_reg(REG_UPPER, 32'sd5000000); write_reg(REG_INIT_VAR, 32'd671089);
      end
      1: begin
        // extremes: saturating arithmetic everywhere
        write_reg(REG_DRIFT, 32'h8000_0000); write_reg(REG_SQRT_STEP, 32'h7fff_ffff);
        write_reg(REG_REVERSION, 32'h7fff_ffff); write_reg(REG_LTV, 32'h7fff_ffff);
        write_reg(REG_VOLVOL, 32'h7fff_ffff); write_reg(REG_LOWER, 32'h7fff_ffff);
        write_reg(REG_UPPER, 32'h8000_0000); write_reg(REG_INIT_VAR, 32'h7fff_ffff);
      end
      2: begin
        write_reg(REG_DRIFT, 32'h7fff_ffff); write_reg(REG_SQRT_STEP, 32'd0);
        write_reg(REG_REVERSION, 32'd0); write_reg(REG_LTV, 32'd0);
        write_reg(REG_VOLVOL, 32'd0); write_reg(REG_LOWER, 32'h8000_0000);
        write_reg(REG_UPPER, 32'h7fff_ffff); write_reg(REG_INIT_VAR, 32'd0);
      end
      default: begin
        write_reg(REG_DRIFT, $urandom_range(40000) - 20000);
        write_reg(REG_SQRT_STEP, $urandom_range(32'h0400_0000));
        write_reg(REG_REVERSION, $urandom_range(32'h0200_0000));
        write_reg(REG_LTV, $urandom_range(32'h0200_0000));
        write_reg(REG_VOLVOL, $urandom_range(32'h0400_0000));
        write_reg(REG_LOWER, -$signed($urandom_range(32'h0800_0000)));
        write_reg(REG_UPPER, $urandom_range(32'h0800_0000));
        write_reg(REG_INIT_VAR, mode == 4 ? $urandom & 32'h7fff_ffff
                                          : $urandom_range(32'h0200_0000));
      end
    endcase
  endtask

  initial begin
    int slot;
    logic first, last;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset registers, then extremes of the samples and slots
    send_step(6'd0, 1, 1, 16'sh7fff, 16'sh8000);
    send_step(6'd63, 1, 0, 16'sh8000, 16'sh7fff);
    send_step(6'd63, 0, 1, 16'sh0, 16'sh0);
    directed_cnt += 3;
    drain();
    program_regs(0);
    for (int i = 0; i < 8; i++) begin
      send_step(6'(i), 1, 0, (i[0] ? 16'sh7fff : 16'sh8000), (i[1] ? 16'sh7fff : 16'sh8000));
      directed_cnt++;
    end
    for (int i = 0; i < 8; i++) begin
      send_step(6'(i), 0, 1, 16'shffff, 16'sh0001);
      directed_cnt++;
    end
    drain();
    program_regs(1);
    send_step(6'd5, 1, 1, 16'sh7fff, 16'sh7fff);
    send_step(6'd42, 1, 0, 16'sh8000, 16'sh8000);
    send_step(6'd42, 0, 1, 16'sh8000, 16'sh8000);
    send_step(6'd21, 1, 1, 16'sh0, 16'sh0);
    directed_cnt += 4;
    drain();
    program_regs(2);
    send_step(6'd9, 1, 1, 16'sh7fff, 16'sh8000);
    directed_cnt++;
    drain();

    // random: interleaved paths of a few steps, settings change between phases
    for (int phase = 0; phase < 6; phase++) begin
      program_regs(phase < 2 ? phase : 3 + (phase % 2));
      calm = (phase == 2);
      for (int n = 0; n < 175; n++) begin
        slot = $urandom_range(63);
        first = !started[slot] || ($urandom_range(7) == 0);
        last = ($urandom_range(4) == 0);
        send_step(6'(slot), first, last, rand_z(), rand_z());
        random_cnt++;
      end
      calm = 0;
      drain();
    end

    $display("Covered %0d directed and %0d random path steps, %0d results checked.",
             directed_cnt, random_cnt, sb.checked);
    if (sb.errors == 0 && sb.pending_done.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
